// File: rtl/chained_dma_register_block_macros.svh
// Assertion macros for the chained DMA register block.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef CHAINED_DMA_REGISTER_BLOCK_MACROS_SVH
`define CHAINED_DMA_REGISTER_BLOCK_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every clock edge outside reset.
`define CDMA_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CDMA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define CDMA_ASSERT_IMP(label, clk, rst_n, a, b)
`define CDMA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/cdma_pkg.sv
// Package of the chained DMA register block: item kinds, register offsets, payload types.
// No dependencies.
package cdma_pkg;

    localparam int NumChannelsDefault = 10;
    localparam int AddrChannels = 10;

    localparam logic [2:0] KIND_READ     = 3'd0;
    localparam logic [2:0] KIND_WRITE    = 3'd1;
    localparam logic [2:0] KIND_REQUEST  = 3'd2;
    localparam logic [2:0] KIND_END      = 3'd3;
    localparam logic [2:0] KIND_SRC_TAG  = 3'd4;
    localparam logic [2:0] KIND_DST_TAG  = 3'd5;
    localparam logic [2:0] KIND_EN_WRITE = 3'd6;
    localparam logic [2:0] KIND_EN_READ  = 3'd7;

    localparam logic [7:0] OFS_CHCR = 8'h00;
    localparam logic [7:0] OFS_MADR = 8'h10;
    localparam logic [7:0] OFS_QWC  = 8'h20;
    localparam logic [7:0] OFS_TADR = 8'h30;
    localparam logic [7:0] OFS_ASR0 = 8'h40;
    localparam logic [7:0] OFS_ASR1 = 8'h50;
    localparam logic [7:0] OFS_SADR = 8'h80;

    localparam logic [15:0] REG_CTRL  = 16'hE000;
    localparam logic [15:0] REG_STAT  = 16'hE010;
    localparam logic [15:0] REG_PCR   = 16'hE020;
    localparam logic [15:0] REG_SQWC  = 16'hE030;
    localparam logic [15:0] REG_RBSR  = 16'hE040;
    localparam logic [15:0] REG_RBOR  = 16'hE050;
    localparam logic [15:0] REG_STADR = 16'hE060;

    localparam logic [2:0] TAG_REFE = 3'd0;
    localparam logic [2:0] TAG_CNT  = 3'd1;
    localparam logic [2:0] TAG_NEXT = 3'd2;
    localparam logic [2:0] TAG_REF  = 3'd3;

    localparam logic [31:0] ENABLE_RESET  = 32'h0000_1201;
    localparam logic [15:0] REQUEST_RESET = 16'h03D7;
    localparam logic [31:0] ADDR_MASK     = ~32'd15;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [31:0] write_data;
        logic [3:0]  channel;
        logic        request_level;
        logic [63:0] tag_word;
    } t_request;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic [9:0]  start_mask;
        logic        tag_end;
        logic        error;
    } t_result;

    // Map bits 15..8 of a channel register address to a channel number.
    function automatic logic [4:0] decode_channel(input logic [7:0] sel);
        logic [4:0] c;
        case (sel)
            8'h80: c = 5'd0;
            8'h90: c = 5'd1;
            8'hA0: c = 5'd2;
            8'hB0: c = 5'd3;
            8'hB4: c = 5'd4;
            8'hC0: c = 5'd5;
            8'hC4: c = 5'd6;
            8'hC8: c = 5'd7;
            8'hD0: c = 5'd8;
            8'hD4: c = 5'd9;
            default: c = 5'd16;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/cdma_if.sv
// Valid/ready channel interface carrying one request or one result.
// Depends on cdma_pkg for the payload types.
interface cdma_req_if;
    logic                valid;
    logic                ready;
    cdma_pkg::t_request  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdma_res_if;
    logic               valid;
    logic               ready;
    cdma_pkg::t_result  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/cdma_out_reg.sv
// Two-entry skid output register for results.
// Depends on cdma_pkg and the macros header.
`include "chained_dma_register_block_macros.svh"
module cdma_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cdma_pkg::t_result   i_data,
    output logic                o_space,
    cdma_res_if.source          o_res
);
    logic [1:0]         r_count;
    cdma_pkg::t_result  r_head;
    cdma_pkg::t_result  r_tail;
    logic               w_pop;

    // Space is taken from the registered count only, so the receiver's ready never
    // reaches the input side in the same cycle.
    assign w_pop   = o_res.valid && o_res.ready;
    assign o_space = (r_count != 2'd2);
    assign o_res.valid = (r_count != 2'd0);
    assign o_res.data  = r_head;

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    // Head and tail entries.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_count == 2'd2) begin
                r_head <= r_tail;
                if (i_push) r_tail <= i_data;
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) r_head <= i_data;
            else r_tail <= i_data;
        end
    end

    `CDMA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_count == 2'd2 && !w_pop, !i_push)
    `CDMA_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `CDMA_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push, o_res.valid)
endmodule

// File: rtl/chained_dma_register_block.sv
// Chained DMA register block: register file, interrupt logic and chain-tag decoder.
// Depends on cdma_pkg, cdma_if, cdma_out_reg and the macros header.
//
// Usage: requests enter on i_req (valid/ready); each gives exactly one result on o_res.
// A request is a register read or write, an enable word read or write, a request line
// change, a transfer end, or a source or destination chain tag for one channel.
// The request is decoded and the state updated in the cycle it is accepted; the result
// is registered in the output register and offered once the results ahead of it are taken.
// Throughput is one request per cycle; a two-entry output register decouples the sides,
// so i_req.ready drops only while both entries are full, which needs a receiver stall.
// Reset clears all registers, sets the enable word to 0x1201 and raises the request
// lines of channels 0-2, 4 and 6-9; the output register empties.
// Result fields: read data, interrupt (status AND mask), the mask of checked channels
// that may start, whether a tag ends the chain, and an error flag for bad access or tag.
`include "chained_dma_register_block_macros.svh"
module chained_dma_register_block #(
    parameter int NUM_CHANNELS = cdma_pkg::NumChannelsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdma_req_if.sink    i_req,
    cdma_res_if.source  o_res
);
    localparam int NC = NUM_CHANNELS;
    localparam int CW = (NC > 1) ? $clog2(NC) : 1;

    logic [23:0] r_ctl   [NC];
    logic [31:0] r_madr  [NC];
    logic [31:0] r_tadr  [NC];
    logic [15:0] r_qwc   [NC];
    logic [31:0] r_asr0  [NC];
    logic [31:0] r_asr1  [NC];
    logic [31:0] r_sadr  [NC];
    logic [NC-1:0] r_req;
    logic [NC-1:0] r_cend;
    logic [10:0] r_ctrl;
    logic [20:0] r_pcr;
    logic [24:0] r_stat;
    logic [31:0] r_en;

    logic               w_space;
    logic               w_acc;
    cdma_pkg::t_request q;
    cdma_pkg::t_result  w_res;

    assign i_req.ready = w_space;
    assign w_acc = i_req.valid && w_space;
    assign q = i_req.data;

    // Address decode.
    logic [4:0]  w_dch;
    logic        w_dok;
    logic [CW-1:0] w_dci;
    logic [7:0]  w_ofs;
    logic        w_is_chan;
    logic        w_chok;
    logic [CW-1:0] w_ci;
    logic [2:0]  w_id;
    logic        w_tag_ok;

    assign w_dch = cdma_pkg::decode_channel(q.address[15:8]);
    assign w_dok = ({27'd0, w_dch} < NC);
    assign w_dci = w_dch[CW-1:0];
    assign w_ofs = q.address[7:0];
    assign w_is_chan = (q.address < cdma_pkg::REG_CTRL);
    assign w_chok = ({28'd0, q.channel} < NC);
    assign w_ci = q.channel[CW-1:0];
    assign w_id = q.tag_word[30:28];
    assign w_tag_ok = (q.kind == cdma_pkg::KIND_SRC_TAG) ? (w_id <= cdma_pkg::TAG_REF)
                                                        : (w_id == cdma_pkg::TAG_CNT);

    // Start condition of one channel from a given set of global and channel values.
    function automatic logic start_ok(input int i, input logic [31:0] en, input logic [10:0] ct,
                                      input logic [20:0] pc, input logic rq, input logic str);
        logic ok;
        ok = !en[16] && ct[0] && rq && str && i < cdma_pkg::AddrChannels;
        if (pc[20] && (i >= cdma_pkg::AddrChannels || !pc[10 + (i % 10)])) ok = 1'b0;
        return ok;
    endfunction

    // Next-state and result logic.
    logic [23:0] n_ctl [NC];
    logic [31:0] n_madr [NC];
    logic [31:0] n_tadr [NC];
    logic [15:0] n_qwc [NC];
    logic [31:0] n_asr0 [NC];
    logic [31:0] n_asr1 [NC];
    logic [31:0] n_sadr [NC];
    logic [NC-1:0] n_req;
    logic [NC-1:0] n_cend;
    logic [10:0] n_ctrl;
    logic [20:0] n_pcr;
    logic [24:0] n_stat;
    logic [31:0] n_en;
    logic [31:0] w_rd;
    logic        w_err;
    logic        w_tend;
    logic [NC-1:0] w_chk;
    logic [9:0]  w_sm;

    always_comb begin
        logic [31:0] d;
        logic [23:0] cc;
        logic [31:0] hi;
        logic [31:0] m;
        logic [9:0]  clr;
        logic [24:0] tog;
        d = q.write_data;
        cc = r_ctl[w_dci];
        hi = q.tag_word[63:32] & cdma_pkg::ADDR_MASK;
        m = 32'd0;
        clr = 10'd0;
        tog = 25'd0;
        n_ctl = r_ctl; n_madr = r_madr; n_tadr = r_tadr; n_qwc = r_qwc;
        n_asr0 = r_asr0; n_asr1 = r_asr1; n_sadr = r_sadr;
        n_req = r_req; n_cend = r_cend; n_ctrl = r_ctrl; n_pcr = r_pcr;
        n_stat = r_stat; n_en = r_en;
        w_rd = 32'd0; w_err = 1'b0; w_tend = 1'b0; w_chk = '0;
        case (q.kind)
            cdma_pkg::KIND_READ: begin
                if (w_is_chan) begin
                    if (!w_dok) w_err = 1'b1;
                    else begin
                        case (w_ofs)
                            cdma_pkg::OFS_CHCR: w_rd = {cc[23:8], 7'd0, cc[7:5], cc[4:3],
                                                        cc[2:1], 1'b0, cc[0]};
                            cdma_pkg::OFS_MADR: w_rd = r_madr[w_dci];
                            cdma_pkg::OFS_QWC:  w_rd = {16'd0, r_qwc[w_dci]};
                            cdma_pkg::OFS_TADR: w_rd = r_tadr[w_dci];
                            default: w_err = 1'b1;
                        endcase
                    end
                end else begin
                    case (q.address)
                        cdma_pkg::REG_CTRL: w_rd = {21'd0, r_ctrl};
                        cdma_pkg::REG_STAT: w_rd = {1'b0, r_stat[24:23], 3'd0, r_stat[22:13],
                                                    r_stat[12:10], 3'd0, r_stat[9:0]};
                        cdma_pkg::REG_PCR:  w_rd = {r_pcr[20], 5'd0, r_pcr[19:10], 6'd0,
                                                    r_pcr[9:0]};
                        cdma_pkg::REG_SQWC, cdma_pkg::REG_RBSR, cdma_pkg::REG_RBOR,
                        cdma_pkg::REG_STADR: w_rd = 32'd0;
                        default: w_err = 1'b1;
                    endcase
                end
            end
            cdma_pkg::KIND_WRITE: begin
                if (w_is_chan) begin
                    if (!w_dok) w_err = 1'b1;
                    else begin
                        case (w_ofs)
                            cdma_pkg::OFS_CHCR: begin
                                n_ctl[w_dci] = {cc[23:8], d[8:6], d[5:4], d[3:2], d[0]};
                                w_chk[w_dci] = 1'b1;
                            end
                            cdma_pkg::OFS_MADR: n_madr[w_dci] = d & cdma_pkg::ADDR_MASK;
                            cdma_pkg::OFS_QWC:  n_qwc[w_dci] = d[15:0];
                            cdma_pkg::OFS_TADR: n_tadr[w_dci] = d & cdma_pkg::ADDR_MASK;
                            cdma_pkg::OFS_ASR0: n_asr0[w_dci] = d & cdma_pkg::ADDR_MASK;
                            cdma_pkg::OFS_ASR1: n_asr1[w_dci] = d & cdma_pkg::ADDR_MASK;
                            cdma_pkg::OFS_SADR: n_sadr[w_dci] = d & cdma_pkg::ADDR_MASK;
                            default: w_err = 1'b1;
                        endcase
                    end
                end else begin
                    case (q.address)
                        cdma_pkg::REG_CTRL: begin
                            n_ctrl = d[10:0];
                            w_chk = '1;
                        end
                        cdma_pkg::REG_STAT: begin
                            clr = d[9:0];
                            tog = {d[30:29], d[25:16], 13'd0};
                            n_stat = ({r_stat[24:13], r_stat[12:10] & ~d[15:13],
                                       r_stat[9:0] & ~clr}) ^ tog;
                        end
                        cdma_pkg::REG_PCR: begin
                            n_pcr = {d[31], d[25:16], d[9:0]};
                            w_chk = '1;
                        end
                        cdma_pkg::REG_SQWC, cdma_pkg::REG_RBSR, cdma_pkg::REG_RBOR: ;
                        default: w_err = 1'b1;
                    endcase
                end
            end
            cdma_pkg::KIND_REQUEST: begin
                if (!w_chok) w_err = 1'b1;
                else begin
                    n_req[w_ci] = q.request_level;
                    w_chk[w_ci] = 1'b1;
                end
            end
            cdma_pkg::KIND_END: begin
                if (!w_chok) w_err = 1'b1;
                else begin
                    n_cend[w_ci] = 1'b0;
                    n_ctl[w_ci][7] = 1'b0;
                    if (q.channel < 4'd10) n_stat[q.channel] = 1'b1;
                end
            end
            cdma_pkg::KIND_SRC_TAG, cdma_pkg::KIND_DST_TAG: begin
                if (!w_chok || !w_tag_ok) w_err = 1'b1;
                else begin
                    n_qwc[w_ci] = q.tag_word[15:0];
                    n_ctl[w_ci] = {q.tag_word[31:16], r_ctl[w_ci][7:0]};
                    w_tend = q.tag_word[31] && r_ctl[w_ci][6];
                    m = r_tadr[w_ci] + 32'd16;
                    if (q.kind == cdma_pkg::KIND_DST_TAG) begin
                        n_madr[w_ci] = hi;
                    end else if (w_id == cdma_pkg::TAG_REFE || w_id == cdma_pkg::TAG_REF) begin
                        n_madr[w_ci] = hi;
                        n_tadr[w_ci] = m;
                        if (w_id == cdma_pkg::TAG_REFE) w_tend = 1'b1;
                    end else begin
                        n_madr[w_ci] = m;
                        n_tadr[w_ci] = (w_id == cdma_pkg::TAG_CNT) ?
                            m + {12'd0, q.tag_word[15:0], 4'd0} : hi;
                    end
                    n_cend[w_ci] = w_tend;
                end
            end
            cdma_pkg::KIND_EN_WRITE: begin
                n_en = d;
                w_chk = '1;
            end
            default: w_rd = r_en;
        endcase
        // Start check on the updated state for the channels this request touches.
        w_sm = 10'd0;
        for (int i = 0; i < NC; i++) begin
            if (i < 10 && w_chk[i] &&
                start_ok(i, n_en, n_ctrl, n_pcr, n_req[i], n_ctl[i][7])) begin
                w_sm[i % 10] = 1'b1;
            end
        end
    end

    assign w_res.read_data  = w_rd;
    assign w_res.irq        = |(n_stat[9:0] & n_stat[22:13]);
    assign w_res.start_mask = w_sm;
    assign w_res.tag_end    = w_tend;
    assign w_res.error      = w_err;

    // State registers, updated when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_ctl[i] <= '0; r_madr[i] <= '0; r_tadr[i] <= '0; r_qwc[i] <= '0;
                r_asr0[i] <= '0; r_asr1[i] <= '0; r_sadr[i] <= '0;
                r_req[i] <= (i < 16) ? cdma_pkg::REQUEST_RESET[i % 16] : 1'b0;
            end
            r_cend <= '0;
            r_ctrl <= '0;
            r_pcr  <= '0;
            r_stat <= '0;
            r_en   <= cdma_pkg::ENABLE_RESET;
        end else if (w_acc) begin
            r_ctl <= n_ctl; r_madr <= n_madr; r_tadr <= n_tadr; r_qwc <= n_qwc;
            r_asr0 <= n_asr0; r_asr1 <= n_asr1; r_sadr <= n_sadr;
            r_req <= n_req; r_cend <= n_cend; r_ctrl <= n_ctrl; r_pcr <= n_pcr;
            r_stat <= n_stat; r_en <= n_en;
        end
    end

    cdma_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_space (w_space),
        .o_res   (o_res)
    );

    `CDMA_ASSERT_IMP(a_err_no_read, i_clk, i_rst_n, w_acc && w_err, w_rd == 32'd0)
    `CDMA_ASSERT_IMP(a_err_no_start, i_clk, i_rst_n, w_acc && w_err, w_sm == 10'd0)
    `CDMA_ASSERT_NEXT(a_err_holds_stat, i_clk, i_rst_n, w_acc && w_err,
                      r_stat == $past(r_stat))
endmodule

// File: bench/chained_dma_register_block_test.sv
// Self-checking testbench of the chained DMA register block: directed and random requests.
// Depends on cdma_pkg, cdma_if and the chained_dma_register_block RTL.
module chained_dma_register_block_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS = 10;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned result_count = 0;
    int unsigned sent_count = 0;
    int unsigned burst_left = 0;

    cdma_req_if req_bus();
    cdma_res_if res_bus();

    chained_dma_register_block uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // Shadow copy of the register file.
    logic [23:0] chcr_shadow [CHANNELS];
    logic [31:0] madr_shadow [CHANNELS];
    logic [31:0] tadr_shadow [CHANNELS];
    logic [15:0] qwc_shadow  [CHANNELS];
    logic [31:0] asr0_shadow [CHANNELS];
    logic [31:0] asr1_shadow [CHANNELS];
    logic [31:0] sadr_shadow [CHANNELS];
    logic        line_shadow [CHANNELS];
    logic        done_shadow [CHANNELS];
    logic [10:0] ctrl_shadow;
    logic [20:0] pcr_shadow;
    logic [24:0] stat_shadow;
    logic [31:0] enable_shadow;

    cdma_pkg::t_result expected_results [$];

    always #5 i_clk = ~i_clk;

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver stalls on a pattern chosen by bits 9..8 of the cycle counter.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            case (cycle_count[9:8])
                2'd0: res_bus.ready <= 1'b1;
                2'd1: res_bus.ready <= ($urandom_range(1) == 1);
                2'd2: res_bus.ready <= ($urandom_range(3) == 0);
                default: res_bus.ready <= (cycle_count[2:0] != 3'd0);
            endcase
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 result_count, field, got, want);
        error_count++;
    endtask

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        cdma_pkg::t_result want;
        cdma_pkg::t_result got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = res_bus.data;
            if (expected_results.size() == 0) begin
                $display("result %0d arrived with nothing expected", result_count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.irq !== want.irq)
                    report_mismatch("irq", 32'(got.irq), 32'(want.irq));
                if (got.start_mask !== want.start_mask)
                    report_mismatch("start_mask", 32'(got.start_mask), 32'(want.start_mask));
                if (got.tag_end !== want.tag_end)
                    report_mismatch("tag_end", 32'(got.tag_end), 32'(want.tag_end));
                if (got.error !== want.error)
                    report_mismatch("error", 32'(got.error), 32'(want.error));
            end
            result_count++;
        end
    end

    function automatic int channel_of(input logic [7:0] sel);
        case (sel)
            8'h80: return 0;
            8'h90: return 1;
            8'hA0: return 2;
            8'hB0: return 3;
            8'hB4: return 4;
            8'hC0: return 5;
            8'hC4: return 6;
            8'hC8: return 7;
            8'hD0: return 8;
            8'hD4: return 9;
            default: return -1;
        endcase
    endfunction

    function automatic logic [9:0] startable(input int first, input int last);
        logic [9:0] m;
        m = '0;
        for (int i = first; i <= last; i++) begin
            if (!enable_shadow[16] && ctrl_shadow[0] && line_shadow[i]
                    && (!pcr_shadow[20] || pcr_shadow[10 + i]) && chcr_shadow[i][7])
                m[i] = 1'b1;
        end
        return m;
    endfunction

    task automatic clear_shadow();
        for (int i = 0; i < CHANNELS; i++) begin
            chcr_shadow[i] = '0;
            madr_shadow[i] = '0;
            tadr_shadow[i] = '0;
            qwc_shadow[i] = '0;
            asr0_shadow[i] = '0;
            asr1_shadow[i] = '0;
            sadr_shadow[i] = '0;
            line_shadow[i] = cdma_pkg::REQUEST_RESET[i];
            done_shadow[i] = 1'b0;
        end
        ctrl_shadow = '0;
        pcr_shadow = '0;
        stat_shadow = '0;
        enable_shadow = cdma_pkg::ENABLE_RESET;
    endtask

    // Register read; returns 0 for an unhandled address.
    function automatic bit read_register(input logic [15:0] a, output logic [31:0] rd);
        int c;
        logic [23:0] cc;
        rd = '0;
        if (a < cdma_pkg::REG_CTRL) begin
            c = channel_of(a[15:8]);
            if (c < 0) return 0;
            cc = chcr_shadow[c];
            case (a[7:0])
                cdma_pkg::OFS_CHCR: rd = {cc[23:8], 7'b0, cc[7:5], cc[4:3], cc[2:1],
                                          1'b0, cc[0]};
                cdma_pkg::OFS_MADR: rd = madr_shadow[c];
                cdma_pkg::OFS_QWC:  rd = {16'b0, qwc_shadow[c]};
                cdma_pkg::OFS_TADR: rd = tadr_shadow[c];
                default: return 0;
            endcase
            return 1;
        end
        case (a)
            cdma_pkg::REG_CTRL: rd = {21'b0, ctrl_shadow};
            cdma_pkg::REG_STAT: rd = {1'b0, stat_shadow[24:23], 3'b0, stat_shadow[22:13],
                                      stat_shadow[12:10], 3'b0, stat_shadow[9:0]};
            cdma_pkg::REG_PCR:  rd = {pcr_shadow[20], 5'b0, pcr_shadow[19:10], 6'b0,
                                      pcr_shadow[9:0]};
            cdma_pkg::REG_SQWC, cdma_pkg::REG_RBSR, cdma_pkg::REG_RBOR,
            cdma_pkg::REG_STADR: rd = '0;
            default: return 0;
        endcase
        return 1;
    endfunction

    // Register write; returns 0 for an unhandled address.
    function automatic bit write_register(input logic [15:0] a, input logic [31:0] d,
                                          output logic [9:0] sm);
        int c;
        logic [12:0] clr;
        logic [11:0] tog;
        sm = '0;
        if (a < cdma_pkg::REG_CTRL) begin
            c = channel_of(a[15:8]);
            if (c < 0) return 0;
            case (a[7:0])
                cdma_pkg::OFS_CHCR: begin
                    chcr_shadow[c] = {chcr_shadow[c][23:8], d[8:6], d[5:4], d[3:2], d[0]};
                    sm = startable(c, c);
                end
                cdma_pkg::OFS_MADR: madr_shadow[c] = d & cdma_pkg::ADDR_MASK;
                cdma_pkg::OFS_QWC:  qwc_shadow[c] = d[15:0];
                cdma_pkg::OFS_TADR: tadr_shadow[c] = d & cdma_pkg::ADDR_MASK;
                cdma_pkg::OFS_ASR0: asr0_shadow[c] = d & cdma_pkg::ADDR_MASK;
                cdma_pkg::OFS_ASR1: asr1_shadow[c] = d & cdma_pkg::ADDR_MASK;
                cdma_pkg::OFS_SADR: sadr_shadow[c] = d & cdma_pkg::ADDR_MASK;
                default: return 0;
            endcase
            return 1;
        end
        case (a)
            cdma_pkg::REG_CTRL: begin
                ctrl_shadow = d[10:0];
                sm = startable(0, CHANNELS - 1);
            end
            cdma_pkg::REG_STAT: begin
                // Interrupt flags clear on 1, mask bits toggle on 1.
                clr = {d[15:13], d[9:0]};
                tog = {d[30:29], d[25:16]};
                stat_shadow = (stat_shadow & ~{12'b0, clr}) ^ {tog, 13'b0};
            end
            cdma_pkg::REG_PCR: begin
                pcr_shadow = {d[31], d[25:16], d[9:0]};
                sm = startable(0, CHANNELS - 1);
            end
            cdma_pkg::REG_SQWC, cdma_pkg::REG_RBSR, cdma_pkg::REG_RBOR: ;
            default: return 0;
        endcase
        return 1;
    endfunction

    // Apply one request to the shadow state and return the result it should give.
    function automatic cdma_pkg::t_result apply_request(input cdma_pkg::t_request r);
        cdma_pkg::t_result res;
        logic [31:0] rd;
        logic [9:0] sm;
        logic [2:0] id;
        logic [31:0] hi;
        logic [31:0] next_addr;
        logic [15:0] cnt;
        int ch;
        bit bad_id;
        res = '0;
        ch = r.channel;
        case (r.kind)
            cdma_pkg::KIND_READ: begin
                if (read_register(r.address, rd)) res.read_data = rd;
                else res.error = 1'b1;
            end
            cdma_pkg::KIND_WRITE: begin
                if (write_register(r.address, r.write_data, sm)) res.start_mask = sm;
                else res.error = 1'b1;
            end
            cdma_pkg::KIND_REQUEST: begin
                if (ch >= CHANNELS) begin
                    res.error = 1'b1;
                end else begin
                    line_shadow[ch] = r.request_level;
                    res.start_mask = startable(ch, ch);
                end
            end
            cdma_pkg::KIND_END: begin
                if (ch >= CHANNELS) begin
                    res.error = 1'b1;
                end else begin
                    done_shadow[ch] = 1'b0;
                    chcr_shadow[ch][7] = 1'b0;
                    stat_shadow[ch] = 1'b1;
                end
            end
            cdma_pkg::KIND_SRC_TAG, cdma_pkg::KIND_DST_TAG: begin
                id = r.tag_word[30:28];
                hi = r.tag_word[63:32] & cdma_pkg::ADDR_MASK;
                cnt = r.tag_word[15:0];
                bad_id = (r.kind == cdma_pkg::KIND_SRC_TAG) ? (id > cdma_pkg::TAG_REF)
                                                            : (id != cdma_pkg::TAG_CNT);
                if (ch >= CHANNELS || bad_id) begin
                    res.error = 1'b1;
                end else begin
                    res.tag_end = r.tag_word[31] && chcr_shadow[ch][6];
                    qwc_shadow[ch] = cnt;
                    chcr_shadow[ch] = {r.tag_word[31:16], chcr_shadow[ch][7:0]};
                    if (r.kind == cdma_pkg::KIND_DST_TAG) begin
                        madr_shadow[ch] = hi;
                    end else if (id == cdma_pkg::TAG_REFE || id == cdma_pkg::TAG_REF) begin
                        madr_shadow[ch] = hi;
                        tadr_shadow[ch] = tadr_shadow[ch] + 32'd16;
                        if (id == cdma_pkg::TAG_REFE) res.tag_end = 1'b1;
                    end else begin
                        next_addr = tadr_shadow[ch] + 32'd16;
                        madr_shadow[ch] = next_addr;
                        tadr_shadow[ch] = (id == cdma_pkg::TAG_CNT) ?
                            next_addr + {12'b0, cnt, 4'b0} : hi;
                    end
                    done_shadow[ch] = res.tag_end;
                end
            end
            cdma_pkg::KIND_EN_WRITE: begin
                enable_shadow = r.write_data;
                res.start_mask = startable(0, CHANNELS - 1);
            end
            default: res.read_data = enable_shadow;
        endcase
        res.irq = |(stat_shadow[9:0] & stat_shadow[22:13]);
        return res;
    endfunction

    // Send one request in bursts with gaps, record its expected result on acceptance.
    task automatic send_request(input logic [2:0] kind, input logic [15:0] address,
                                input logic [31:0] data, input logic [3:0] channel,
                                input logic level, input logic [63:0] tag);
        cdma_pkg::t_request r;
        r = '{kind: kind, address: address, write_data: data, channel: channel,
              request_level: level, tag_word: tag};
        if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(12, 1);
        end
        req_bus.valid <= 1'b1;
        req_bus.data <= r;
        do @(posedge i_clk); while (!req_bus.ready);
        expected_results.push_back(apply_request(r));
        sent_count++;
        burst_left--;
    endtask

    task automatic test_registers();
        send_request(cdma_pkg::KIND_READ, 16'h8000 | cdma_pkg::OFS_CHCR, '0, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_WRITE, 16'hD400 | cdma_pkg::OFS_CHCR, 32'hFFFF_FFFF,
                     4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_READ, 16'hD400 | cdma_pkg::OFS_CHCR, '0, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_WRITE, 16'h9000 | cdma_pkg::OFS_MADR, 32'hFFFF_FFFF,
                     4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_WRITE, 16'hB400 | cdma_pkg::OFS_ASR0, 32'h1234_5678,
                     4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_READ, 16'hB400 | cdma_pkg::OFS_ASR1, '0, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_WRITE, cdma_pkg::REG_STADR, 32'h1, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_READ, cdma_pkg::REG_RBOR, '0, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_WRITE, 16'h1234, 32'h5, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_EN_READ, '0, '0, 4'd0, 1'b0, '0);
    endtask

    task automatic test_start_and_status();
        send_request(cdma_pkg::KIND_WRITE, cdma_pkg::REG_CTRL, 32'hFFFF_FFFF, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_EN_WRITE, '0, 32'h0, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_WRITE, cdma_pkg::REG_PCR, 32'h8001_03FF, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_REQUEST, '0, '0, 4'd3, 1'b1, '0);
        send_request(cdma_pkg::KIND_END, '0, '0, 4'd9, 1'b0, '0);
        send_request(cdma_pkg::KIND_WRITE, cdma_pkg::REG_STAT, 32'hFFFF_FFFF, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_READ, cdma_pkg::REG_STAT, '0, 4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_REQUEST, '0, '0, 4'd15, 1'b1, '0);
    endtask

    task automatic test_tags();
        send_request(cdma_pkg::KIND_WRITE, 16'h8000 | cdma_pkg::OFS_CHCR, 32'h40,
                     4'd0, 1'b0, '0);
        send_request(cdma_pkg::KIND_SRC_TAG, '0, '0, 4'd0, 1'b0, 64'hFFFF_FFFF_8000_0010);
        send_request(cdma_pkg::KIND_SRC_TAG, '0, '0, 4'd0, 1'b0, 64'h0000_0000_9ABC_FFFF);
        send_request(cdma_pkg::KIND_SRC_TAG, '0, '0, 4'd0, 1'b0, 64'hFFFF_FFF0_A000_0001);
        send_request(cdma_pkg::KIND_SRC_TAG, '0, '0, 4'd0, 1'b0, 64'h1234_5678_3000_0002);
        send_request(cdma_pkg::KIND_SRC_TAG, '0, '0, 4'd0, 1'b0, 64'h0000_0000_7000_0000);
        send_request(cdma_pkg::KIND_DST_TAG, '0, '0, 4'd0, 1'b0, 64'hABCD_EF01_9000_0004);
        send_request(cdma_pkg::KIND_DST_TAG, '0, '0, 4'd12, 1'b0, 64'h0000_0000_1000_0000);
    endtask

    function automatic logic [15:0] pick_address();
        logic [7:0] selects [10] = '{8'h80, 8'h90, 8'hA0, 8'hB0, 8'hB4,
                                    8'hC0, 8'hC4, 8'hC8, 8'hD0, 8'hD4};
        logic [7:0] offsets [7] = '{cdma_pkg::OFS_CHCR, cdma_pkg::OFS_MADR,
                                    cdma_pkg::OFS_QWC, cdma_pkg::OFS_TADR,
                                    cdma_pkg::OFS_ASR0, cdma_pkg::OFS_ASR1,
                                    cdma_pkg::OFS_SADR};
        logic [15:0] globals [7] = '{cdma_pkg::REG_CTRL, cdma_pkg::REG_STAT,
                                     cdma_pkg::REG_PCR, cdma_pkg::REG_SQWC,
                                     cdma_pkg::REG_RBSR, cdma_pkg::REG_RBOR,
                                     cdma_pkg::REG_STADR};
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return {selects[$urandom_range(9)], offsets[$urandom_range(6)]};
        if (pick < 9) return globals[$urandom_range(6)];
        return 16'($urandom());
    endfunction

    // Mostly well-formed traffic: channels armed, DMA enabled, tag chains walked.
    task automatic test_random(input int count);
        logic [31:0] d;
        logic [63:0] tag;
        logic [3:0] ch;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            d = $urandom();
            ch = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10))
                                          : 4'($urandom_range(CHANNELS - 1));
            tag = {32'($urandom()), 32'($urandom())};
            if ($urandom_range(4) != 0) tag[30] = 1'b0;
            if (pick < 20) begin
                send_request(cdma_pkg::KIND_READ, pick_address(), d, ch, 1'b0, tag);
            end else if (pick < 45) begin
                if ($urandom_range(2) == 0) d[7] = 1'b1;
                send_request(cdma_pkg::KIND_WRITE, pick_address(), d, ch, 1'b0, tag);
            end else if (pick < 55) begin
                send_request(cdma_pkg::KIND_REQUEST, 16'($urandom()), d, ch,
                             1'($urandom()), tag);
            end else if (pick < 62) begin
                send_request(cdma_pkg::KIND_END, 16'($urandom()), d, ch, 1'b0, tag);
            end else if (pick < 80) begin
                send_request(cdma_pkg::KIND_SRC_TAG, 16'($urandom()), d, ch, 1'b0, tag);
            end else if (pick < 88) begin
                if ($urandom_range(3) != 0) tag[30:28] = cdma_pkg::TAG_CNT;
                send_request(cdma_pkg::KIND_DST_TAG, 16'($urandom()), d, ch, 1'b0, tag);
            end else if (pick < 94) begin
                if ($urandom_range(3) != 0) d[16] = 1'b0;
                send_request(cdma_pkg::KIND_EN_WRITE, 16'($urandom()), d, ch, 1'b0, tag);
            end else begin
                send_request(cdma_pkg::KIND_EN_READ, 16'($urandom()), d, ch, 1'b0, tag);
            end
        end
    endtask

    initial begin
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        clear_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_registers();
        test_start_and_status();
        test_tags();
        test_random(750);
        req_bus.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d requests (registers, start checks, status, chain tags, enable word)",
                 sent_count);
        $display("Checked %0d results, %0d mismatches", result_count, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/cdma_pkg.sv
rtl/cdma_if.sv
rtl/cdma_out_reg.sv
rtl/chained_dma_register_block.sv
bench/chained_dma_register_block_test.sv
